// ===== hw/rtl/tsavg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsavg_pkg
// shared constants and control types for the ternary segment averager
// ----------------------------------------------------------------------------
package tsavg_pkg;

	// default parameter values
	localparam int MAX_RUN_DEF      = 1024;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int ACCEL_W = 16;
	localparam int THR_W   = 15;
	localparam int CLS_W   = 2;
	localparam int MEAN_W  = 16;

	// threshold after reset: 0.4 g in q4.12
	localparam logic [THR_W-1:0] THR_RESET = 15'd1638;

	// per-axis class codes
	localparam logic [CLS_W-1:0] CLS_NEUTRAL = 2'd0;
	localparam logic [CLS_W-1:0] CLS_POS     = 2'd1;
	localparam logic [CLS_W-1:0] CLS_NEG     = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;    // capture the input transaction
		logic update;  // apply the item to the run state, start divide if needed
		logic put;     // load the output register
	} tsavg_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic has_result;  // held item produces a result
		logic closes;      // held item closes the open run
		logic div_busy;    // divider lanes are running
		logic out_free;    // output register can take a new result
	} tsavg_sts_t;

endpackage

// ===== hw/rtl/tsavg_div.sv =====
// ----------------------------------------------------------------------------
// tsavg_div
// bit-serial restoring divide of a signed run sum by the unsigned run count
// ----------------------------------------------------------------------------
module tsavg_div #(
	parameter int SUMW = 26,
	parameter int CNTW = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [SUMW-1:0] sum,
	input  logic [CNTW-1:0]        count,
	output logic                   busy,
	output logic signed [SUMW-1:0] quot
);

	localparam int STW = $clog2(SUMW + 1);

	logic [STW-1:0]  step_q;
	logic [SUMW-1:0] dvd_q;
	logic [CNTW-1:0] rem_q;
	logic [CNTW-1:0] dvs_q;
	logic            neg_q;

	logic [CNTW:0]   shifted;
	logic            ge;
	logic [CNTW:0]   diff;

	assign shifted = {rem_q, dvd_q[SUMW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};
	assign busy    = step_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STW'(SUMW);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= sum[SUMW-1] ? (-sum) : sum;
			neg_q <= sum[SUMW-1];
			rem_q <= '0;
			dvs_q <= count;
		end else if (busy) begin
			dvd_q <= {dvd_q[SUMW-2:0], ge};
			rem_q <= ge ? diff[CNTW-1:0] : shifted[CNTW-1:0];
		end
	end

	// truncation toward zero: divide magnitudes, then restore the sign
	assign quot = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

// ===== hw/rtl/tsavg_dp.sv =====
// ----------------------------------------------------------------------------
// tsavg_dp
// datapath: input capture, classification, run sums, divider lanes, output
// ----------------------------------------------------------------------------
module tsavg_dp #(
	parameter int MAX_RUN      = tsavg_pkg::MAX_RUN_DEF,
	parameter int SAMPLE_WIDTH = tsavg_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsavg_pkg::tsavg_cmd_t                cmd,
	output tsavg_pkg::tsavg_sts_t                sts,
	input  logic                                 cfg_valid,
	input  logic [tsavg_pkg::THR_W-1:0]          cfg_data,
	input  logic                                 pressed,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_z,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [tsavg_pkg::CLS_W-1:0]          class_x,
	output logic [tsavg_pkg::CLS_W-1:0]          class_y,
	output logic [tsavg_pkg::CLS_W-1:0]          class_z,
	output logic                                 run_closed,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_x,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_y,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_z,
	output logic                                 gesture_end
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int AW   = tsavg_pkg::ACCEL_W;
	localparam int CLW  = tsavg_pkg::CLS_W;
	localparam int MW   = tsavg_pkg::MEAN_W;
	localparam int SUMW = SW + $clog2(MAX_RUN);
	localparam int CNTW = $clog2(MAX_RUN + 1);
	localparam int CW   = ((SW > AW) ? SW : AW) + 1;
	localparam int QW   = (SUMW > MW) ? SUMW : MW;

	// input capture
	logic          pressed_q;
	logic [AW-1:0] accel_q [3];

	// run state
	logic [3*CLW-1:0]      last_cls_q;
	logic signed [SUMW-1:0] sum_q [3];
	logic [CNTW-1:0]        cnt_q;
	logic                   active_q;
	logic [tsavg_pkg::THR_W-1:0] thr_q;

	// staged result fields
	logic [3*CLW-1:0] res_cls_q;
	logic             res_closed_q;
	logic             res_end_q;

	// output register
	logic                  out_valid_q;
	logic [CLW-1:0]        out_cls_q [3];
	logic                  out_closed_q;
	logic                  out_end_q;
	logic signed [MW-1:0]  out_mean_q [3];

	logic signed [SW-1:0]   smp [3];
	logic [SW+AW-1:0]       smp_ext [3];
	logic [CLW-1:0]         cls [3];
	logic [3*CLW-1:0]       cls_pk;
	logic signed [CW-1:0]   t_pos;
	logic signed [CW-1:0]   t_neg;
	logic signed [CW-1:0]   smp_c [3];
	logic signed [SUMW-1:0] quot [3];
	logic signed [QW-1:0]   quot_ext [3];
	logic                   div_busy [3];
	logic                   has_result;
	logic                   closes;
	logic                   div_start;

	assign t_pos = CW'({1'b0, thr_q});
	assign t_neg = -t_pos;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			// bits above the sample width are ignored
			smp_ext[k] = {{SW{1'b0}}, accel_q[k]};
			smp[k]     = $signed(smp_ext[k][SW-1:0]);
			smp_c[k]   = CW'(smp[k]);
			if (smp_c[k] > t_pos) begin
				cls[k] = tsavg_pkg::CLS_POS;
			end else if (smp_c[k] < t_neg) begin
				cls[k] = tsavg_pkg::CLS_NEG;
			end else begin
				cls[k] = tsavg_pkg::CLS_NEUTRAL;
			end
		end
	end

	assign cls_pk     = {cls[2], cls[1], cls[0]};
	assign has_result = pressed_q | active_q;
	assign closes     = !pressed_q | (cls_pk != last_cls_q);
	assign div_start  = cmd.update & has_result & closes;

	assign sts.has_result = has_result;
	assign sts.closes     = closes;
	assign sts.div_busy   = div_busy[0] | div_busy[1] | div_busy[2];
	assign sts.out_free   = !out_valid_q | !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tsavg_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pressed_q  <= pressed;
			accel_q[0] <= accel_x;
			accel_q[1] <= accel_y;
			accel_q[2] <= accel_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cls_q <= '0;
			cnt_q      <= CNTW'(1);
			active_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= '0;
			end
		end else if (cmd.update && has_result) begin
			if (pressed_q) begin
				last_cls_q <= cls_pk;
				active_q   <= 1'b1;
				if (closes) begin
					cnt_q <= CNTW'(1);
					for (int k = 0; k < 3; k++) begin
						sum_q[k] <= SUMW'(smp[k]);
					end
				end else if (cnt_q < CNTW'(MAX_RUN)) begin
					cnt_q <= cnt_q + 1'b1;
					for (int k = 0; k < 3; k++) begin
						sum_q[k] <= sum_q[k] + SUMW'(smp[k]);
					end
				end
			end else begin
				// release: back to neutral class with a phantom zero sample
				last_cls_q <= '0;
				cnt_q      <= CNTW'(1);
				active_q   <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && has_result) begin
			res_cls_q    <= cls_pk;
			res_closed_q <= closes;
			res_end_q    <= !pressed_q;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		tsavg_div #(
			.SUMW(SUMW),
			.CNTW(CNTW)
		) u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (div_start),
			.sum   (sum_q[g]),
			.count (cnt_q),
			.busy  (div_busy[g]),
			.quot  (quot[g])
		);
		assign quot_ext[g] = QW'(quot[g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_closed_q <= res_closed_q;
			out_end_q    <= res_end_q;
			for (int k = 0; k < 3; k++) begin
				out_cls_q[k]  <= res_cls_q[k*CLW +: CLW];
				out_mean_q[k] <= res_closed_q ? quot_ext[k][MW-1:0] : '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign class_x     = out_cls_q[0];
	assign class_y     = out_cls_q[1];
	assign class_z     = out_cls_q[2];
	assign run_closed  = out_closed_q;
	assign gesture_end = out_end_q;
	assign mean_x      = out_mean_q[0];
	assign mean_y      = out_mean_q[1];
	assign mean_z      = out_mean_q[2];

endmodule

// ===== hw/rtl/tsavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsavg_ctrl
// controller: sequences capture, run update, divide and output load
// ----------------------------------------------------------------------------
module tsavg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tsavg_pkg::tsavg_sts_t sts,
	output tsavg_pkg::tsavg_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall   = state_q != ST_IDLE;
	assign cmd.take   = (state_q == ST_IDLE) & in_valid;
	assign cmd.update = state_q == ST_EVAL;
	assign cmd.put    = (state_q == ST_PUT) & sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.has_result) begin
					state_d = ST_IDLE;
				end else if (sts.closes) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/accel_ternary_segment_averager.sv =====
// ----------------------------------------------------------------------------
// accel_ternary_segment_averager
// ternary class runs over 3-axis acceleration with truncated run means
// ----------------------------------------------------------------------------
// While pressed is high, each axis of a q4.12 sample is classed positive
// (above threshold), negative (below -threshold) or neutral, and samples of
// an unchanged 3-axis class are summed into a run (count saturates at
// MAX_RUN). Every pressed transaction gives one result; a class change gives
// the finished run's mean, truncated toward zero. A release transaction
// while a gesture is active gives the release class and the open run's mean,
// then the run restarts neutral with one phantom zero sample. A release
// while idle gives nothing. One item is in work at a time: an item that
// continues a run passes through evaluate and output load; an item that
// closes a run or ends a gesture also waits for the bit-serial restoring
// divider, whose step count is SUMW = SAMPLE_WIDTH + clog2(MAX_RUN), three
// lanes sharing the run count as divisor and producing one quotient bit
// per cycle; a release while idle goes from evaluate straight back to idle.
// A finished result waits in the output register while the next item is
// taken. The threshold register is written through the cfg channel,
// which is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module accel_ternary_segment_averager #(
	parameter int MAX_RUN      = tsavg_pkg::MAX_RUN_DEF,
	parameter int SAMPLE_WIDTH = tsavg_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tsavg_pkg::THR_W-1:0]          cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 pressed,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [tsavg_pkg::ACCEL_W-1:0] accel_z,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [tsavg_pkg::CLS_W-1:0]          class_x,
	output logic [tsavg_pkg::CLS_W-1:0]          class_y,
	output logic [tsavg_pkg::CLS_W-1:0]          class_z,
	output logic                                 run_closed,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_x,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_y,
	output logic signed [tsavg_pkg::MEAN_W-1:0]  mean_z,
	output logic                                 gesture_end
);

	tsavg_pkg::tsavg_cmd_t cmd;
	tsavg_pkg::tsavg_sts_t sts;

	// users change the register only while idle, unenforced; writes never wait
	assign cfg_ready = 1'b1;

	// sequencer: idle, evaluate, divide, output load
	tsavg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// classification, run state, divider lanes and output register
	tsavg_dp #(
		.MAX_RUN     (MAX_RUN),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.pressed    (pressed),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.class_x    (class_x),
		.class_y    (class_y),
		.class_z    (class_z),
		.run_closed (run_closed),
		.mean_x     (mean_x),
		.mean_y     (mean_y),
		.mean_z     (mean_z),
		.gesture_end(gesture_end)
	);

`ifndef SYNTH
	// one item at a time: an accepted transaction blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an accept");

	// the divider never runs while the input side is open
	a_div_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> in_stall)
		else $error("divider busy while input not stalled");

	// a new result never overwrites one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !(out_valid && out_stall))
		else $error("output register loaded while stalled");

	// gesture end always closes a run, and an open run reports zero means
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!gesture_end || run_closed) &&
			(run_closed || (mean_x == '0 && mean_y == '0 && mean_z == '0))))
		else $error("inconsistent result flags or means");
`endif

endmodule
